// ===== sv/ptme_pkg.sv =====
// Package holding the shared types and constants of the page table map engine.
`default_nettype none
package ptme_pkg;
    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_MAP = 2'd1;
    localparam logic [1:0] CMD_RD_PDE = 2'd2;
    localparam logic [1:0] CMD_RD_PTE = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_NO_TABLE = 2'd2;
    localparam logic [31:0] E_P = 32'h1;
    localparam logic [31:0] E_RW = 32'h2;
    localparam logic [31:0] E_U = 32'h4;
    localparam logic [31:0] E_PS = 32'h80;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int ENTRY_IDX_W = 10;
    localparam int CFG_IDX_BASE = 0;
    localparam int CFG_IDX_SLOTS = 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INIT   = 8'b0000_0010,
        S_RDPDE  = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_FILL   = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_RDPTE  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;
endpackage
`default_nettype wire

// ===== sv/ptme_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module ptme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== sv/page_table_map_engine.sv =====
// Top level of the page table map engine: directory and table store sequencer.
`default_nettype none
// Usage
// A command word is taken on a rising edge where i_start is high and o_busy is
// low. Exactly one result word follows, shown for one cycle with o_done high;
// the receiver cannot stall it, so it must sample on that cycle.
// The directory (1024 entries) and the table store (TABLE_SLOTS tables of
// 1024 entries) each live in a single-port RAM with a registered read. The
// block handles one command at a time.
// Steps per command: init directory writes one directory entry per cycle;
// read directory entry passes S_RDPDE and S_DECIDE, read table entry also
// S_RDPTE; a refused map ends after S_DECIDE; a map into an existing table
// writes the entry in S_WRITE; a map with a new table or a split first runs
// S_FILL, since the new table is filled one entry per cycle through the
// store's only port before the addressed entry is written.
// After reset a pass over all directory entries clears them, during which
// o_busy stays high; configuration writes are taken at any time. The table
// store has no reset; only entries of allocated tables are ever read.
// Configuration: i_cfg_we, i_cfg_index (0 pool base frame, 1 pool size) and
// i_cfg_wdata, written on the edge where i_cfg_we is high.
module page_table_map_engine #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_virtual_address,
    input  wire logic [31:0] i_physical_address,
    input  wire logic [11:0] i_page_flags,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [19:0] i_cfg_wdata,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [31:0]      o_entry_value,
    output logic             o_table_allocated,
    output logic             o_large_page_split
);
    import ptme_pkg::*;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int TS_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
    localparam int TS_AW = $clog2(TS_DEPTH);

    t_state r_state, n_state;
    logic [19:0] r_base;
    logic [4:0] r_pool;
    logic [CNT_W-1:0] r_next;
    logic [ENTRY_IDX_W:0] r_cnt;       // sweep counter, one bit wider than the entry index
    logic r_clearing;
    logic [1:0] r_cmd;
    logic [9:0] r_di, r_ti;
    logic [31:0] r_pa_val;
    logic [11:0] r_flags;
    logic [31:0] r_pde;
    logic [SLOT_W-1:0] r_slot;
    logic r_split;
    logic [1:0] r_status;
    logic [31:0] r_value;
    logic r_alloc;
    logic r_done;

    // Directory RAM port.
    logic pd_we;
    logic [9:0] pd_addr;
    logic [31:0] pd_wdata, pd_rdata;
    // Table store RAM port.
    logic ts_we;
    logic [TS_AW-1:0] ts_addr;
    logic [31:0] ts_wdata, ts_rdata;

    ptme_ram #(.WIDTH(32), .DEPTH(1024)) u_dir (
        .i_clk(i_clk), .i_we(pd_we), .i_addr(pd_addr),
        .i_wdata(pd_wdata), .o_rdata(pd_rdata)
    );
    ptme_ram #(.WIDTH(32), .DEPTH(TS_DEPTH)) u_tables (
        .i_clk(i_clk), .i_we(ts_we), .i_addr(ts_addr),
        .i_wdata(ts_wdata), .o_rdata(ts_rdata)
    );

    // Effective pool size: min(pool register, TABLE_SLOTS).
    logic [CNT_W-1:0] pool_size;
    always_comb begin
        if (32'(r_pool) > TABLE_SLOTS) begin
            pool_size = CNT_W'(TABLE_SLOTS);
        end else begin
            pool_size = CNT_W'(r_pool);
        end
    end

    // Slot decode of the directory entry just read.
    logic [19:0] pde_off;
    logic pde_slot_ok;
    assign pde_off = pd_rdata[31:12] - r_base;
    assign pde_slot_ok = (32'(pde_off) < 32'(r_next)) && (32'(pde_off) < TABLE_SLOTS);

    logic need_new;
    assign need_new = pd_rdata[7] || !pd_rdata[0];
    logic [19:0] new_frame;
    assign new_frame = r_base + 20'(r_next);

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE) || r_clearing;

    logic [31:0] map_val;
    assign map_val = {r_pa_val[31:12], r_flags};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        pd_we = 1'b0;
        pd_addr = r_di;
        pd_wdata = '0;
        ts_we = 1'b0;
        ts_addr = TS_AW'({r_slot, r_ti});
        ts_wdata = map_val;
        if (r_clearing) begin
            pd_we = 1'b1;
            pd_addr = r_cnt[9:0];
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_INIT) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_RDPDE;
                    end
                end
            end
            S_INIT: begin
                pd_we = 1'b1;
                pd_addr = r_cnt[9:0];
                pd_wdata = {r_cnt[9:0], 22'd0} | E_P | E_RW | E_PS;
                if (r_cnt == 11'(ENTRIES_PER_TABLE - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_RDPDE: n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_cmd == CMD_MAP) begin
                    if (need_new) begin
                        if (r_next < pool_size) begin
                            pd_we = 1'b1;
                            pd_wdata = {new_frame, 12'd0} | E_P | E_RW
                                       | (32'(r_flags) & E_U);
                            n_state = S_FILL;
                        end
                    end else if (pde_slot_ok) begin
                        pd_we = 1'b1;
                        pd_wdata = pd_rdata | (32'(r_flags) & E_U);
                        n_state = S_WRITE;
                    end
                end else if (r_cmd == CMD_RD_PTE) begin
                    if (pd_rdata[0] && !pd_rdata[7] && pde_slot_ok) begin
                        ts_addr = TS_AW'({SLOT_W'(pde_off), r_ti});
                        n_state = S_RDPTE;
                    end
                end
            end
            S_FILL: begin
                ts_we = 1'b1;
                ts_addr = TS_AW'({r_slot, r_cnt[9:0]});
                ts_wdata = r_split ? (({r_pde[31:22], 22'd0} + {10'd0, r_cnt[9:0], 12'd0})
                                      | E_P | E_RW) : 32'd0;
                if (r_cnt == 11'(ENTRIES_PER_TABLE - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ts_we = 1'b1;
                n_state = S_DONE;
            end
            S_RDPTE: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= 20'd1024;
            r_pool <= 5'd16;
            r_next <= '0;
            r_cnt <= '0;
            r_clearing <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= (r_state == S_DONE);
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(CFG_IDX_BASE)) begin
                    r_base <= i_cfg_wdata;
                end else begin
                    r_pool <= i_cfg_wdata[4:0];
                end
            end
            if (r_clearing) begin
                if (r_cnt == 11'(ENTRIES_PER_TABLE - 1)) begin
                    r_clearing <= 1'b0;
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_state == S_INIT || r_state == S_FILL) begin
                r_cnt <= (r_cnt == 11'(ENTRIES_PER_TABLE - 1)) ? '0 : r_cnt + 1'b1;
            end
            if (r_state == S_DECIDE && r_cmd == CMD_MAP && need_new
                && r_next < pool_size) begin
                r_next <= r_next + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_di <= i_virtual_address[31:22];
            r_ti <= i_virtual_address[21:12];
            r_pa_val <= i_physical_address;
            r_flags <= i_page_flags;
            r_status <= ST_OK;
            r_value <= '0;
            r_alloc <= 1'b0;
            r_split <= 1'b0;
        end
        if (r_state == S_DECIDE) begin
            r_pde <= pd_rdata;
            unique case (r_cmd)
                CMD_RD_PDE: r_value <= pd_rdata;
                CMD_MAP: begin
                    if (need_new) begin
                        if (r_next < pool_size) begin
                            r_slot <= SLOT_W'(r_next);
                            r_alloc <= 1'b1;
                            r_split <= pd_rdata[7];
                            r_value <= map_val;
                        end else begin
                            r_status <= ST_NO_FRAME;
                        end
                    end else if (pde_slot_ok) begin
                        r_slot <= SLOT_W'(pde_off);
                        r_value <= map_val;
                    end else begin
                        r_status <= ST_NO_TABLE;
                    end
                end
                CMD_RD_PTE: begin
                    if (!(pd_rdata[0] && !pd_rdata[7] && pde_slot_ok)) begin
                        r_status <= ST_NO_TABLE;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_RDPTE) begin
            r_value <= ts_rdata;
        end
    end

    assign o_done = r_done;
    assign o_status = r_status;
    assign o_entry_value = r_value;
    assign o_table_allocated = r_alloc;
    assign o_large_page_split = r_split;

`ifndef SYNTH
    // Allocation never runs past TABLE_SLOTS.
    a_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_next) <= TABLE_SLOTS) else $error("slot counter past pool");
    // A split always comes with an allocation.
    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_large_page_split |-> o_table_allocated)
        else $error("split without allocation");
    // No command is taken during the clearing pass.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> r_state == S_IDLE) else $error("command during clear");
    // The result strobe lasts one cycle.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
`endif
endmodule
`default_nettype wire
